// ----- rtl/core/smstore_pkg.sv -----
// ----------------------------------------------------------------------------
// smstore_pkg
// shared types and constants for the sparse matrix store
// ----------------------------------------------------------------------------
package smstore_pkg;

	localparam int unsigned ValueWidth = 32;
	localparam int unsigned CountOutWidth = 7;

	typedef enum logic {
		FUNC_WRITE = 1'b0,
		FUNC_READ  = 1'b1
	} func_t;

	typedef struct packed {
		logic op_en;
		logic erase;
		logic overwrite;
		logic insert;
		logic shift_en;
	} cell_ctrl_t;

endpackage

// ----- rtl/core/sparse_matrix_store.sv -----
// ----------------------------------------------------------------------------
// sparse_matrix_store
// dictionary-of-keys sparse matrix held in a chain of key/value slots
// ----------------------------------------------------------------------------
//  channel  dir  handshake          payload
//  s_*      in   s_tvalid/s_tready  tdata: row, col, value   tuser: func
//  m_*      out  m_tvalid/m_tready  tdata: cell_value, count tuser: full_drop
//  cfg_*    in   cfg_wr_en          cfg_wr_data: empty_value
//
//  a transaction is registered in the s1 stage and executed from it into the
//  output register; one transaction per cycle when nothing stalls; the
//  parallel key compare over all slots sets this. an erase leaves a hole
//  that walks to the end of the chain one slot per idle cycle; an insert
//  that follows an erase waits until the settle counter runs out. reset
//  clears all valid bits at once; a full output register stalls.
// ----------------------------------------------------------------------------
module sparse_matrix_store #(
	parameter int unsigned CAPACITY = 64,
	parameter int unsigned COORD_WIDTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,     // row[15:0], col[31:16], value[63:32]
	input  logic [0:0]  s_tuser,     // func[0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,     // cell_value[31:0], occupied_count[38:32], zero[39]
	output logic [0:0]  m_tuser,     // full_drop[0]
	input  logic        cfg_wr_en,
	input  logic [31:0] cfg_wr_data
);
	import smstore_pkg::*;

	localparam int unsigned KW = COORD_WIDTH;
	localparam int unsigned CW = $clog2(CAPACITY + 1);
	localparam int unsigned SettleMax = 2 * CAPACITY;
	localparam int unsigned SW = $clog2(SettleMax + 1);

	logic [ValueWidth-1:0] empty_value_q;

	logic                  req_valid_s1;
	func_t                 req_func_s1;
	logic [KW-1:0]         req_row_s1;
	logic [KW-1:0]         req_col_s1;
	logic [ValueWidth-1:0] req_value_s1;

	logic [CW-1:0]         count_q;
	logic [SW-1:0]         settle_q;

	logic                  m_valid_q;
	logic [ValueWidth-1:0] m_value_q;
	logic [CountOutWidth-1:0] m_count_q;
	logic                  m_drop_q;

	logic [CAPACITY-1:0]   c_valid;
	logic [KW-1:0]         c_row   [CAPACITY];
	logic [KW-1:0]         c_col   [CAPACITY];
	logic [ValueWidth-1:0] c_value [CAPACITY];
	logic [CAPACITY-1:0]   c_hit;

	logic                  any_hit;
	logic [ValueWidth-1:0] hit_value;
	logic                  is_read;
	logic                  is_default;
	logic                  do_erase;
	logic                  do_overwrite;
	logic                  need_insert;
	logic                  store_full;
	logic                  do_insert;
	logic                  do_drop;
	logic                  out_free;
	logic                  exec_fire;
	logic [CW-1:0]         count_next;
	logic [ValueWidth-1:0] result_value;
	cell_ctrl_t            ctrl;

	always_comb begin
		hit_value = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			hit_value = hit_value | (c_hit[i] ? c_value[i] : '0);
		end
	end

	assign any_hit      = |c_hit;
	assign is_read      = (req_func_s1 == FUNC_READ);
	assign is_default   = (req_value_s1 == empty_value_q);
	assign do_erase     = !is_read && is_default && any_hit;
	assign do_overwrite = !is_read && !is_default && any_hit;
	assign need_insert  = !is_read && !is_default && !any_hit;
	assign store_full   = (count_q == CW'(CAPACITY));
	assign do_insert    = need_insert && !store_full;
	assign do_drop      = need_insert && store_full;
	assign out_free     = !m_valid_q || m_tready;
	assign exec_fire    = req_valid_s1 && out_free && !(do_insert && (settle_q != '0));
	assign s_tready     = !req_valid_s1 || exec_fire;

	always_comb begin
		count_next = count_q;
		if (do_erase) begin
			count_next = count_q - CW'(1);
		end else if (do_insert) begin
			count_next = count_q + CW'(1);
		end
	end

	always_comb begin
		if (is_read) begin
			result_value = any_hit ? hit_value : empty_value_q;
		end else if (do_overwrite || do_insert) begin
			result_value = req_value_s1;
		end else begin
			result_value = empty_value_q;
		end
	end

	assign ctrl.op_en     = exec_fire;
	assign ctrl.erase     = do_erase;
	assign ctrl.overwrite = do_overwrite;
	assign ctrl.insert    = do_insert;
	assign ctrl.shift_en  = !exec_fire;

	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		logic                  lv;
		logic                  nv;
		logic [KW-1:0]         nr;
		logic [KW-1:0]         nc;
		logic [ValueWidth-1:0] nval;

		if (g == 0) begin : g_first
			assign lv = 1'b1;
		end else begin : g_mid
			assign lv = c_valid[g-1];
		end

		if (g == CAPACITY - 1) begin : g_last
			assign nv   = 1'b0;
			assign nr   = '0;
			assign nc   = '0;
			assign nval = '0;
		end else begin : g_link
			assign nv   = c_valid[g+1];
			assign nr   = c_row[g+1];
			assign nc   = c_col[g+1];
			assign nval = c_value[g+1];
		end

		smstore_cell #(
			.KW  (KW),
			.CW  (CW),
			.IDX (g)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.q_row      (req_row_s1),
			.q_col      (req_col_s1),
			.q_value    (req_value_s1),
			.ins_idx    (count_q),
			.left_valid (lv),
			.nxt_valid  (nv),
			.nxt_row    (nr),
			.nxt_col    (nc),
			.nxt_value  (nval),
			.valid      (c_valid[g]),
			.row        (c_row[g]),
			.col        (c_col[g]),
			.value      (c_value[g]),
			.hit        (c_hit[g])
		);
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			empty_value_q <= '0;
			req_valid_s1  <= 1'b0;
			count_q       <= '0;
			settle_q      <= '0;
			m_valid_q     <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				empty_value_q <= cfg_wr_data;
			end
			if (s_tvalid && s_tready) begin
				req_valid_s1 <= 1'b1;
			end else if (exec_fire) begin
				req_valid_s1 <= 1'b0;
			end
			if (exec_fire) begin
				count_q <= count_next;
			end
			if (exec_fire && do_erase) begin
				settle_q <= SW'(SettleMax);
			end else if (!exec_fire && (settle_q != '0)) begin
				settle_q <= settle_q - SW'(1);
			end
			if (exec_fire) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			req_func_s1  <= func_t'(s_tuser[0]);
			req_row_s1   <= KW'(s_tdata[15:0]);
			req_col_s1   <= KW'(s_tdata[31:16]);
			req_value_s1 <= s_tdata[63:32];
		end
		if (exec_fire) begin
			m_value_q <= result_value;
			m_count_q <= CountOutWidth'(count_next);
			m_drop_q  <= do_drop;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {1'b0, m_count_q, m_value_q};
	assign m_tuser  = m_drop_q;

endmodule

// ----- rtl/core/smstore_cell.sv -----
// ----------------------------------------------------------------------------
// smstore_cell
// one slot of the store: key compare, update, and hole compaction from the
// right-hand neighbor
// ----------------------------------------------------------------------------
module smstore_cell #(
	parameter int unsigned KW = 16,
	parameter int unsigned CW = 7,
	parameter int unsigned IDX = 0
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  smstore_pkg::cell_ctrl_t               ctrl,
	input  logic [KW-1:0]                         q_row,
	input  logic [KW-1:0]                         q_col,
	input  logic [smstore_pkg::ValueWidth-1:0]    q_value,
	input  logic [CW-1:0]                         ins_idx,
	input  logic                                  left_valid,
	input  logic                                  nxt_valid,
	input  logic [KW-1:0]                         nxt_row,
	input  logic [KW-1:0]                         nxt_col,
	input  logic [smstore_pkg::ValueWidth-1:0]    nxt_value,
	output logic                                  valid,
	output logic [KW-1:0]                         row,
	output logic [KW-1:0]                         col,
	output logic [smstore_pkg::ValueWidth-1:0]    value,
	output logic                                  hit
);
	import smstore_pkg::*;

	logic                  valid_q;
	logic [KW-1:0]         row_q;
	logic [KW-1:0]         col_q;
	logic [ValueWidth-1:0] value_q;
	logic                  take_ins;
	logic                  take_nxt;
	logic                  give;

	assign hit      = valid_q && (row_q == q_row) && (col_q == q_col);
	assign take_ins = ctrl.insert && (ins_idx == CW'(IDX));
	assign take_nxt = !valid_q && nxt_valid;
	assign give     = valid_q && !left_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.op_en) begin
			if (hit && ctrl.erase) begin
				valid_q <= 1'b0;
			end else if (take_ins) begin
				valid_q <= 1'b1;
			end
		end else if (ctrl.shift_en) begin
			if (take_nxt) begin
				valid_q <= 1'b1;
			end else if (give) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.op_en) begin
			if (hit && ctrl.overwrite) begin
				value_q <= q_value;
			end else if (take_ins) begin
				row_q   <= q_row;
				col_q   <= q_col;
				value_q <= q_value;
			end
		end else if (ctrl.shift_en && take_nxt) begin
			row_q   <= nxt_row;
			col_q   <= nxt_col;
			value_q <= nxt_value;
		end
	end

	assign valid = valid_q;
	assign row   = row_q;
	assign col   = col_q;
	assign value = value_q;

endmodule
